FILE: hw/rtl/rle_pkg.sv
// Shared types and constants for the run-length stream decompressor.
package rle_pkg;

   // Field widths of the result beat.
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned TOTAL_W = 32;

   // Default depth of the queue between the parser and the output stage.
   localparam int unsigned RLE_QUEUE_DEPTH = 4;

   // One decoded result as it travels through the queue.
   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [COUNT_W-1:0] repeat_count;
      logic               frame_end;
      logic [TOTAL_W-1:0] total_count;
   } rsp_type;

   // Push request from the parser into the queue.
   typedef struct packed {
      logic    push;
      rsp_type data;
   } push_type;

endpackage

FILE: hw/rtl/rle_stream_decompressor.sv
// A result beat is stored in the queue as its byte is accepted, then moves to the output register for rsp_.
// Throughput: one compressed byte per cycle; req_stall rises only when the result
// queue (QueueDepth entries) is full because the rsp_ side is stalling.
// Control words give no result, header bytes only an empty-frame end beat; one beat per whole run.
// Reset (synchronous, active high) empties the queue and output register and puts
// the parser back at header byte 0 with all counters cleared.
module rle_stream_decompressor #(
   parameter int unsigned QueueDepth = rle_pkg::RLE_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rle_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rle_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [rle_pkg::COUNT_W-1:0]  rsp_repeat_count,
   output logic                         rsp_frame_end,
   output logic [rle_pkg::TOTAL_W-1:0]  rsp_total_count
);
   import rle_pkg::*;

   push_type push_bus;
   rsp_type  queue_head;
   logic     queue_full;
   logic     queue_not_empty;
   logic     queue_pop;

   // Front: parse the byte stream into result beats.
   rle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push_out      (push_bus)
   );

   // Queue decouples parsing from output back-pressure.
   rle_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push_bus),
      .pop       (queue_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // Back: registered output beat.
   rle_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_not_empty  (queue_not_empty),
      .queue_head       (queue_head),
      .queue_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_total_count  (rsp_total_count)
   );

endmodule

FILE: hw/rtl/rle_front.sv
// Stream parser: walks header, control words, run values and literals.
module rle_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_data_byte,
   input  logic               queue_full,
   output logic               req_stall,
   output rle_pkg::push_type  push_out
);
   import rle_pkg::*;

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_CTRL_LO = 3'd1;
   localparam logic [2:0] PH_CTRL_HI = 3'd2;
   localparam logic [2:0] PH_RUN     = 3'd3;
   localparam logic [2:0] PH_LIT     = 3'd4;

   logic [2:0]         phase_ff, phase_in;
   logic [2:0]         hdr_idx_ff, hdr_idx_in;
   logic [TOTAL_W-1:0] remain_ff, remain_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [7:0]         ctrl_low_ff, ctrl_low_in;
   logic [COUNT_W-1:0] left_ff, left_in;

   logic               accept;
   logic [2:0]         idx;
   logic [15:0]        word;
   logic [COUNT_W-1:0] pkt_len;
   logic               exhausted;
   logic               hdr_exhausted;
   logic               last_lit;

   // The parser holds off the stream only while the queue has no room.
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign word      = {req_data_byte, ctrl_low_ff};
   assign pkt_len   = {1'b0, word[14:0]} + COUNT_W'(1);
   assign exhausted = (remain_ff == '0) || remain_ff[TOTAL_W-1];
   assign last_lit  = (left_ff <= COUNT_W'(1));
   assign idx       = (phase_ff == PH_HEADER) ? hdr_idx_ff : 3'd0;
   assign hdr_exhausted = (remain_in == '0) || remain_in[TOTAL_W-1];

   // Next-state and result generation for one accepted byte.
   always_comb begin
      phase_in    = phase_ff;
      hdr_idx_in  = hdr_idx_ff;
      remain_in   = remain_ff;
      total_in    = total_ff;
      ctrl_low_in = ctrl_low_ff;
      left_in     = left_ff;
      push_out    = '0;
      push_out.data.out_byte    = req_data_byte;
      push_out.data.total_count = total_ff;
      case (phase_ff)
         PH_CTRL_LO: begin
            ctrl_low_in = req_data_byte;
            phase_in    = PH_CTRL_HI;
         end
         PH_CTRL_HI: begin
            total_in  = total_ff + TOTAL_W'(pkt_len);
            remain_in = remain_ff - TOTAL_W'(pkt_len);
            left_in   = pkt_len;
            phase_in  = word[15] ? PH_LIT : PH_RUN;
         end
         PH_RUN: begin
            push_out.push              = accept;
            push_out.data.repeat_count = left_ff;
            push_out.data.frame_end    = exhausted;
            left_in    = '0;
            phase_in   = exhausted ? PH_HEADER : PH_CTRL_LO;
            hdr_idx_in = 3'd0;
         end
         PH_LIT: begin
            push_out.push              = accept;
            push_out.data.repeat_count = COUNT_W'(1);
            push_out.data.frame_end    = last_lit && exhausted;
            left_in    = last_lit ? '0 : left_ff - COUNT_W'(1);
            if (last_lit) begin
               phase_in = exhausted ? PH_HEADER : PH_CTRL_LO;
            end
            hdr_idx_in = 3'd0;
         end
         default: begin
            // Header bytes; an unused phase code restarts the header.
            phase_in = PH_HEADER;
            if (idx == 3'd0) begin
               remain_in = '0;
            end
            case (idx)
               3'd4:    remain_in[7:0]   = remain_ff[7:0]   | req_data_byte;
               3'd5:    remain_in[15:8]  = remain_ff[15:8]  | req_data_byte;
               3'd6:    remain_in[23:16] = remain_ff[23:16] | req_data_byte;
               3'd7:    remain_in[31:24] = remain_ff[31:24] | req_data_byte;
               default: ;
            endcase
            if (idx != 3'd7) begin
               hdr_idx_in = idx + 3'd1;
            end else begin
               hdr_idx_in = 3'd0;
               total_in   = '0;
               left_in    = '0;
               if (hdr_exhausted) begin
                  push_out.push              = accept;
                  push_out.data.out_byte     = '0;
                  push_out.data.repeat_count = '0;
                  push_out.data.frame_end    = 1'b1;
                  push_out.data.total_count  = '0;
               end else begin
                  phase_in = PH_CTRL_LO;
               end
            end
         end
      endcase
   end

   // Parser state advances only on an accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hdr_idx_ff  <= 3'd0;
         remain_ff   <= '0;
         total_ff    <= '0;
         ctrl_low_ff <= '0;
         left_ff     <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         remain_ff   <= remain_in;
         total_ff    <= total_in;
         ctrl_low_ff <= ctrl_low_in;
         left_ff     <= left_in;
      end
   end

endmodule

FILE: hw/rtl/rle_queue.sv
// Short queue of decoded results between the parser and the output stage.
module rle_queue #(
   parameter int unsigned QueueDepth = rle_pkg::RLE_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  rle_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output rle_pkg::rsp_type  head
);
   import rle_pkg::*;

   localparam int unsigned PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CNT_W = $clog2(QueueDepth + 1);

   rsp_type            slots_ff [QueueDepth];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(QueueDepth));
   assign not_empty = (count_ff != '0);
   assign do_push   = push_in.push;
   assign do_pop    = pop && not_empty;
   assign head      = slots_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_in.data;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(do_push && full))
      else $error("queue written while full");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QueueDepth))
      else $error("queue occupancy out of range");

   a_pop_only_when_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_first_push_lands: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop && count_ff == '0) |=> count_ff == CNT_W'(1))
      else $error("push into empty queue lost");
`endif

endmodule

FILE: hw/rtl/rle_back.sv
// Output stage: holds one result beat and presents it on the rsp_ channel.
module rle_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         queue_not_empty,
   input  rle_pkg::rsp_type             queue_head,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rle_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [rle_pkg::COUNT_W-1:0]  rsp_repeat_count,
   output logic                         rsp_frame_end,
   output logic [rle_pkg::TOTAL_W-1:0]  rsp_total_count
);
   import rle_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type beat_ff;

   // Load a new beat whenever the register is empty or being drained.
   assign queue_pop = queue_not_empty && (!valid_ff || !rsp_stall);
   assign valid_in  = queue_pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         beat_ff <= queue_head;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = beat_ff.out_byte;
   assign rsp_repeat_count = beat_ff.repeat_count;
   assign rsp_frame_end    = beat_ff.frame_end;
   assign rsp_total_count  = beat_ff.total_count;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the run-length stream decompressor.
`timescale 1ns / 100ps

module tb;
   import rle_pkg::*;

   // Decoder position within the compressed stream.
   typedef enum logic [2:0] {
      HDR,
      CTRL_LO,
      CTRL_HI,
      RUN_VALUE,
      LIT_BYTES
   } dec_phase_type;

   // One row of the directed stream: a byte and, where obvious, its result beat.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      bit                typed;
      rsp_type           want;
   } dir_row_type;

   localparam int N_DIR        = 31;
   localparam int ITEMS_PER_MIX = 455;
   localparam int MAX_REPORTS  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [COUNT_W-1:0]  rsp_repeat_count;
   logic                rsp_frame_end;
   logic [TOTAL_W-1:0]  rsp_total_count;

   // Mirror of the decoder state.
   dec_phase_type       dec_phase = HDR;
   logic [2:0]          hdr_idx = '0;
   logic [31:0]         size_left = '0;
   logic [31:0]         total_q = '0;
   logic [7:0]          ctrl_low_q = '0;
   logic [15:0]         lits_left = '0;

   // Plans for the well-formed part of the stream.
   logic [31:0]         size_plan;
   logic [15:0]         ctrl_plan;

   rsp_type             pending_beats[$];
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  mismatch_count = 0;
   int                  beats_checked = 0;
   int                  frames_ended = 0;
   int                  empty_frames = 0;
   int                  bytes_sent = 0;

   dir_row_type dir_rows [N_DIR] = '{
      // Negative size with ignored header bytes at their extremes: empty frame.
      '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
      '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h80, 1'b1, '{8'h00, 16'd0, 1'b1, 32'd0}},
      // Size one with the longest run: the final packet is taken whole.
      '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
      '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0},
      '{8'h5A, 1'b1, '{8'h5A, 16'h8000, 1'b1, 32'd32768}},
      // Size two as a packet of two literals; the whole packet counts at once.
      '{8'h01, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h04, 1'b0, '0}, '{8'h08, 1'b0, '0},
      '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
      '{8'h01, 1'b0, '0}, '{8'h80, 1'b0, '0},
      '{8'hFF, 1'b1, '{8'hFF, 16'd1, 1'b0, 32'd2}},
      '{8'h00, 1'b1, '{8'h00, 16'd1, 1'b1, 32'd2}}
   };

   rle_stream_decompressor u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_total_count  (rsp_total_count)
   );

   always #5 clock = ~clock;

   // The frame is spent once the remaining size is zero or negative.
   function automatic bit size_spent();
      return (size_left == 32'd0) || size_left[31];
   endfunction

   // Advances the mirrored decoder by one byte; returns 1 when a beat is due.
   function automatic bit decode_byte(input logic [7:0] b, output rsp_type beat);
      logic [15:0] word;
      logic [15:0] n;
      bit          last;
      beat = '0;
      decode_byte = 1'b0;
      case (dec_phase)
         CTRL_LO: begin
            ctrl_low_q = b;
            dec_phase  = CTRL_HI;
         end
         CTRL_HI: begin
            word      = {b, ctrl_low_q};
            n         = {1'b0, word[14:0]} + 16'd1;
            total_q   = total_q + {16'd0, n};
            size_left = size_left - {16'd0, n};
            lits_left = n;
            dec_phase = word[15] ? LIT_BYTES : RUN_VALUE;
         end
         RUN_VALUE: begin
            beat.out_byte     = b;
            beat.repeat_count = lits_left;
            beat.frame_end    = size_spent();
            beat.total_count  = total_q;
            lits_left         = '0;
            dec_phase         = beat.frame_end ? HDR : CTRL_LO;
            hdr_idx           = '0;
            decode_byte       = 1'b1;
         end
         LIT_BYTES: begin
            last              = lits_left <= 16'd1;
            beat.out_byte     = b;
            beat.repeat_count = 16'd1;
            beat.frame_end    = last && size_spent();
            beat.total_count  = total_q;
            lits_left         = last ? 16'd0 : lits_left - 16'd1;
            if (last) begin
               dec_phase = beat.frame_end ? HDR : CTRL_LO;
            end
            hdr_idx     = '0;
            decode_byte = 1'b1;
         end
         default: begin
            // Header bytes 4 to 7 build the signed size, little-endian.
            if (hdr_idx == 3'd0) begin
               size_left = '0;
            end
            if (hdr_idx >= 3'd4) begin
               size_left = size_left | ({24'd0, b} << (8 * (hdr_idx - 3'd4)));
            end
            if (hdr_idx < 3'd7) begin
               hdr_idx = hdr_idx + 3'd1;
            end else begin
               hdr_idx   = '0;
               total_q   = '0;
               lits_left = '0;
               if (size_spent()) begin
                  beat.frame_end = 1'b1;
                  decode_byte    = 1'b1;
               end else begin
                  dec_phase = CTRL_LO;
               end
            end
         end
      endcase
   endfunction

   // Chooses the next stream byte: mostly well-formed frames, with some noise.
   function automatic logic [7:0] pick_byte();
      int r;
      bit noise;
      r = $urandom_range(99);
      noise = ($urandom_range(99) < 4);
      case (dec_phase)
         CTRL_LO: begin
            if (!size_left[31] && size_left >= 32'd4096) begin
               ctrl_plan = {1'b0, 15'($urandom_range(32767, 4095))};
            end else if (r < 40) begin
               ctrl_plan = {1'b0, 15'($urandom_range(15))};
            end else if (r < 45) begin
               ctrl_plan = {1'b0, 15'($urandom)};
            end else if (r < 48) begin
               ctrl_plan = 16'h7FFF;
            end else if (r < 51) begin
               ctrl_plan = 16'h8000 | 16'($urandom_range(63));
            end else begin
               ctrl_plan = 16'h8000 | 16'($urandom_range(7));
            end
            return noise ? 8'($urandom) : ctrl_plan[7:0];
         end
         CTRL_HI: return ctrl_plan[15:8];
         RUN_VALUE, LIT_BYTES: return 8'($urandom);
         default: begin
            if (hdr_idx == 3'd4) begin
               if (r < 8) begin
                  size_plan = '0;
               end else if (r < 16) begin
                  size_plan = {1'b1, 31'($urandom)};
               end else if (r < 20) begin
                  size_plan = 32'($urandom_range(200000, 40000));
               end else begin
                  size_plan = 32'($urandom_range(24, 1));
               end
            end
            // Noise may garble the two low size bytes, never the upper ones.
            if (hdr_idx < 3'd4 || (noise && hdr_idx < 3'd6)) begin
               return 8'($urandom);
            end
            return size_plan[8 * (hdr_idx - 3'd4) +: 8];
         end
      endcase
   endfunction

   // Offers one byte, waits for it to be taken and records what it should yield.
   task automatic send_beat(input logic [7:0] b, input bit typed, input rsp_type want);
      rsp_type beat;
      bit      has_beat;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      has_beat = decode_byte(b, beat);
      if (typed) begin
         pending_beats.push_back(want);
      end else if (has_beat) begin
         pending_beats.push_back(beat);
      end
   endtask

   // Holds the sender off until every outstanding beat has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Result side: random stall and a field-by-field check of each beat taken.
   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_checked++;
            if (rsp_frame_end) begin
               frames_ended++;
               if (rsp_repeat_count == '0) begin
                  empty_frames++;
               end
            end
            if (pending_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected beat byte=%02h rep=%0d end=%0b total=%0d",
                           $realtime, rsp_out_byte, rsp_repeat_count, rsp_frame_end,
                           rsp_total_count);
               end
            end else begin
               want = pending_beats.pop_front();
               bad = (rsp_out_byte != want.out_byte)
                  || (rsp_repeat_count != want.repeat_count)
                  || (rsp_frame_end != want.frame_end)
                  || (rsp_total_count != want.total_count);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("%0t: mismatch expected byte=%02h rep=%0d end=%0b total=%0d",
                              $realtime, want.out_byte, want.repeat_count, want.frame_end,
                              want.total_count);
                     $display("%0t:          actual   byte=%02h rep=%0d end=%0b total=%0d",
                              $realtime, rsp_out_byte, rsp_repeat_count, rsp_frame_end,
                              rsp_total_count);
                  end
               end
            end
         end
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // Stimulus: reset, the directed stream, then four mixes of idling and stalling.
   initial begin
      int mix_idle [4];
      int mix_stall [4];
      mix_idle  = '{0, 65, 0, 12};
      mix_stall = '{0, 0, 65, 12};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < N_DIR; i++) begin
         send_beat(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);
      end
      drain_results();

      for (int m = 0; m < 4; m++) begin
         idle_pct  = mix_idle[m];
         stall_pct = mix_stall[m];
         for (int i = 0; i < ITEMS_PER_MIX; i++) begin
            send_beat(pick_byte(), 1'b0, '0);
         end
         drain_results();
      end

      // Let any stray beat show up before the verdict.
      idle_pct  = 0;
      stall_pct = 0;
      repeat (20) @(posedge clock);

      $display("Sent %0d compressed bytes under four idle and stall mixes.", bytes_sent);
      $display("Checked %0d result beats: %0d frame ends, %0d of them empty frames.",
               beats_checked, frames_ended, empty_frames);
      if (mismatch_count == 0 && pending_beats.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Timed out with %0d beats outstanding.", pending_beats.size());
      $display("tb NOT OK");
      $finish;
   end

endmodule
